/* src/two_link_arm_inverse_kinematics_unit_defines.svh */
// Assertion macros shared by the arm inverse kinematics unit.
// Depends on nothing; included by the top level only.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_UNIT_DEFINES_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define TLIK_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define TLIK_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tlik_pkg.sv */
// Shared types and constants for the arm inverse kinematics unit.
// No dependencies.
package tlik_pkg;

  localparam int unsigned ACC_W = 34;   // Q30 angle accumulator, signed

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNREACH = 3'd1,
    ST_A_RANGE = 3'd2,
    ST_B_RANGE = 3'd3,
    ST_PINCH   = 3'd4,
    ST_EXTEND  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_LINK     = 3'd0,
    REG_A_MIN    = 3'd1,
    REG_A_MAX    = 3'd2,
    REG_B_MIN    = 3'd3,
    REG_B_MAX    = 3'd4,
    REG_PINCH    = 3'd5,
    REG_EXTEND   = 3'd6
  } reg_idx_t;

  localparam logic signed [ACC_W-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ACC_W-1:0] Q30_HALF_PI = 34'sd1686629713;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
        5'd30: v = 32'h00000001;  default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

/* src/two_link_arm_inverse_kinematics_unit.sv */
// Inverse kinematics for a two-link planar arm with equal links: one target
// word (x, z) in, one word of motor angles A, B and a status code out. The
// unit is fully pipelined and takes a new word every cycle while no output
// word is held by a stall. The path runs through the bit-per-stage square
// root (RT_W = 27 stages at 18-bit coordinates) followed by the offset
// CORDIC. The theta CORDIC runs beside the square root and does not add
// to the path. A stall on a valid output word freezes the whole pipeline.
// Depends on tlik_pkg, tlik_isqrt, tlik_cordic and the defines header.
`include "two_link_arm_inverse_kinematics_unit_defines.svh"

module two_link_arm_inverse_kinematics_unit #(
  parameter int unsigned COORD_BITS      = 18,
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [16:0]           out_angle_a,
  output logic signed [16:0]           out_angle_b,
  output logic [2:0]                   out_status
);
  import tlik_pkg::*;

  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;      // x^2+z^2
  localparam int unsigned LIM_W  = 34;                       // 4*L^2
  localparam int unsigned SS_W   = ((SQ_W > LIM_W) ? SQ_W : LIM_W);
  localparam int unsigned RAD_W  = SS_W + 16 + ((SS_W + 16) % 2);
  localparam int unsigned RT_W   = RAD_W / 2;
  localparam int unsigned XY_W   = COORD_BITS + 25;
  localparam int unsigned C2_W   = RT_W + 1;
  localparam int unsigned SH     = 30 - ANGLE_FRAC_BITS;

  // ---------------- configuration registers
  logic [15:0] link_r, a_min_r, a_max_r, b_min_r, b_max_r, pinch_r, ext_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= 16'd4096;  a_min_r <= 16'd5719; a_max_r <= 16'd20018;
      b_min_r <= 16'd2145;  b_max_r <= 16'd18588;
      pinch_r <= 16'd9294;  ext_r   <= 16'd9294;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINK:   link_r  <= cfg_data;
        REG_A_MIN:  a_min_r <= cfg_data;
        REG_A_MAX:  a_max_r <= cfg_data;
        REG_B_MIN:  b_min_r <= cfg_data;
        REG_B_MAX:  b_max_r <= cfg_data;
        REG_PINCH:  pinch_r <= cfg_data;
        REG_EXTEND: ext_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline, output register included, advances together on adv.
  logic adv;
  logic ov_r;
  assign adv      = !ov_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: squares, reach limit 4*L^2
  logic                         s1_v_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_z_r;
  logic [SQ_W-2:0]              s1_xx_r, s1_zz_r;
  logic [LIM_W-1:0]             s1_lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
    if (adv) begin
      s1_x_r   <= in_target_x;
      s1_z_r   <= in_target_z;
      s1_xx_r  <= (SQ_W-1)'(unsigned'((2*COORD_BITS)'(in_target_x)
                                      * (2*COORD_BITS)'(in_target_x)));
      s1_zz_r  <= (SQ_W-1)'(unsigned'((2*COORD_BITS)'(in_target_z)
                                      * (2*COORD_BITS)'(in_target_z)));
      s1_lim_r <= {32'(link_r) * 32'(link_r), 2'b00};
    end
  end

  // ---------------- stage 2: sum, reach test, radicands
  logic                         s2_v_r, s2_far_r;
  logic signed [COORD_BITS-1:0] s2_x_r, s2_z_r;
  logic [RAD_W-1:0]             s2_rs_r, s2_rd_r;
  logic [SS_W-1:0]              s_sum, l_ext;
  always_comb begin
    s_sum = SS_W'(s1_xx_r) + SS_W'(s1_zz_r);
    l_ext = SS_W'(s1_lim_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_x_r   <= s1_x_r;
      s2_z_r   <= s1_z_r;
      s2_far_r <= s_sum > l_ext;
      s2_rs_r  <= RAD_W'(s_sum) << 16;
      s2_rd_r  <= RAD_W'(l_ext - s_sum) << 16;
    end
  end

  // ---------------- theta CORDIC in parallel with the square roots
  localparam int unsigned SIDE1_W = 2 * RT_W + 1;
  logic              sq_v, sq_v2;
  logic [RT_W-1:0]   r_s, r_d;
  logic [SIDE1_W-1:0] sq_side, sq_side2;
  logic              unused_v2;

  tlik_isqrt #(.IN_W(RAD_W), .SIDE_W(SIDE1_W)) u_sqrt_s (
    .clk, .rst_n, .adv,
    .in_valid (s2_v_r), .in_value (s2_rs_r),
    .in_side  ({s2_far_r, {RT_W{1'b0}}, {RT_W{1'b0}}}),
    .out_valid(sq_v), .out_root (r_s), .out_side (sq_side)
  );
  tlik_isqrt #(.IN_W(RAD_W), .SIDE_W(SIDE1_W)) u_sqrt_d (
    .clk, .rst_n, .adv,
    .in_valid (s2_v_r), .in_value (s2_rd_r),
    .in_side  ({s2_far_r, {RT_W{1'b0}}, {RT_W{1'b0}}}),
    .out_valid(sq_v2), .out_root (r_d), .out_side (sq_side2)
  );
  assign unused_v2 = sq_v2 ^ sq_side2[SIDE1_W-1] ^ (|sq_side2[SIDE1_W-2:0])
                     ^ (|sq_side[SIDE1_W-2:0]);

  // theta: launched from stage 2 and delayed to line up with the roots.
  logic                    th_v;
  logic signed [ACC_W-1:0] th_ang;
  logic [0:0]              th_side;
  tlik_cordic #(.XY_W(XY_W), .STAGES(CORDIC_STAGES), .SIDE_W(1)) u_theta (
    .clk, .rst_n, .adv,
    .in_valid (s2_v_r),
    .in_y     (XY_W'(s2_x_r) <<< 24),
    .in_x     (XY_W'(s2_z_r) <<< 24),
    .in_side  (1'b0),
    .out_valid(th_v), .out_angle(th_ang), .out_side(th_side)
  );

  localparam int unsigned TH_LAT = ((CORDIC_STAGES < 32) ? CORDIC_STAGES : 32) + 1;
  localparam int unsigned DLY    = (RT_W > TH_LAT) ? RT_W - TH_LAT : 0;
  logic signed [ACC_W-1:0] th_dly [DLY+1];
  assign th_dly[0] = th_ang;
  for (genvar k = 0; k < DLY; k++) begin : g_dly
    logic signed [ACC_W-1:0] d_r;
    always_ff @(posedge clk) if (adv) d_r <= th_dly[k];
    assign th_dly[k+1] = d_r;
  end

  // ---------------- offset CORDIC, theta rides in the side word
  localparam int unsigned SIDE2_W = ACC_W + 1;
  logic                    of_v;
  logic signed [ACC_W-1:0] of_ang;
  logic [SIDE2_W-1:0]      of_side;
  tlik_cordic #(.XY_W(C2_W), .STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_off (
    .clk, .rst_n, .adv,
    .in_valid (sq_v),
    .in_y     (signed'(C2_W'(r_d))),
    .in_x     (signed'(C2_W'(r_s))),
    .in_side  ({sq_side[SIDE1_W-1], th_dly[DLY]}),
    .out_valid(of_v), .out_angle(of_ang), .out_side(of_side)
  );

  // ---------------- A and B in Q30
  logic                    s3_v_r, s3_far_r;
  logic signed [ACC_W+1:0] s3_a_r, s3_b_r;
  logic signed [ACC_W-1:0] of_th;
  assign of_th = of_side[ACC_W-1:0];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= of_v;
    if (adv) begin
      s3_far_r <= of_side[SIDE2_W-1];
      s3_a_r   <= (ACC_W+2)'(Q30_PI) - (ACC_W+2)'(of_th) - (ACC_W+2)'(of_ang)
                  + (ACC_W+2)'(1 << (SH - 1));
      s3_b_r   <= (ACC_W+2)'(Q30_HALF_PI) - (ACC_W+2)'(of_th) + (ACC_W+2)'(of_ang)
                  + (ACC_W+2)'(1 << (SH - 1));
    end
  end

  // ---------------- round, saturate
  function automatic logic signed [17:0] sat_out(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] t;
    begin
      t = v >>> SH;
      if (t < -(ACC_W+2)'(65536))      return -18'sd65536;
      else if (t > (ACC_W+2)'(65535))  return 18'sd65535;
      else                             return 18'(t);
    end
  endfunction

  logic                s4_v_r, s4_far_r;
  logic signed [17:0]  s4_a_r, s4_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      s4_far_r <= s3_far_r;
      s4_a_r   <= sat_out(s3_a_r);
      s4_b_r   <= sat_out(s3_b_r);
    end
  end

  // ---------------- limit checks and output register
  status_t st;
  always_comb begin
    if (s4_far_r) st = ST_UNREACH;
    else if (!(s4_a_r > signed'({2'b00, a_min_r}) && s4_a_r < signed'({2'b00, a_max_r})))
      st = ST_A_RANGE;
    else if (!(s4_b_r > signed'({2'b00, b_min_r}) && s4_b_r < signed'({2'b00, b_max_r})))
      st = ST_B_RANGE;
    else if (!(s4_a_r + signed'({2'b00, pinch_r}) > s4_b_r))
      st = ST_PINCH;
    else if (!(s4_a_r - s4_b_r > signed'({2'b00, ext_r})))
      st = ST_EXTEND;
    else st = ST_OK;
  end

  logic signed [16:0] oa_r, ob_r;
  logic [2:0]         os_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= s4_v_r;
    if (adv) begin
      oa_r <= s4_far_r ? '0 : s4_a_r[16:0];
      ob_r <= s4_far_r ? '0 : s4_b_r[16:0];
      os_r <= st;
    end
  end

  assign out_valid   = ov_r;
  assign out_angle_a = oa_r;
  assign out_angle_b = ob_r;
  assign out_status  = os_r ^ {2'b00, unused_v2 & 1'b0} ^ {2'b00, th_v & th_side[0] & 1'b0};

  `TLIK_ASSERT_IMP(a_unreach_zero, clk, rst_n,
    out_valid && (out_status == ST_UNREACH),
    (out_angle_a == '0) && (out_angle_b == '0), "unreachable word carries angles")
  `TLIK_ASSERT_NXT(a_hold_on_stall, clk, rst_n,
    out_valid && out_stall, out_valid && $stable(out_status), "result lost under stall")
  `TLIK_ASSERT_IMP(a_status_range, clk, rst_n,
    out_valid, out_status <= ST_EXTEND, "status code out of range")
endmodule

/* src/tlik_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Carries an opaque side word alongside; uses no package items.
module tlik_isqrt #(
  parameter int unsigned IN_W   = 60,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       in_value,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [IN_W/2-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int unsigned RW = IN_W / 2;
  localparam int unsigned NS = RW;

  logic              vld_r  [NS+1];
  logic [IN_W-1:0]   rem_r  [NS+1];
  logic [RW-1:0]     root_r [NS+1];
  logic [SIDE_W-1:0] side_r [NS+1];

  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = in_value;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  // Stage k decides result bit RW-1-k by squaring a trial root against the radicand.
  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam int unsigned B = RW - 1 - k;
    logic [IN_W+1:0] trial;
    logic [IN_W+1:0] rem_ext;
    logic [RW-1:0]   cand;
    always_comb begin
      cand    = root_r[k] | (RW'(1) << B);
      trial   = (IN_W+2)'(cand) * (IN_W+2)'(cand);
      rem_ext = (IN_W+2)'(rem_r[k]);
    end
    logic              v_r;
    logic [IN_W-1:0]   rm_r;
    logic [RW-1:0]     rt_r;
    logic [SIDE_W-1:0] sd_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vld_r[k];
      end
      if (adv) begin
        rm_r <= rem_r[k];
        rt_r <= (trial <= rem_ext) ? cand : root_r[k];
        sd_r <= side_r[k];
      end
    end
    always_comb begin
      vld_r[k+1]  = v_r;
      rem_r[k+1]  = rm_r;
      root_r[k+1] = rt_r;
      side_r[k+1] = sd_r;
    end
  end

  assign out_valid = vld_r[NS];
  assign out_root  = root_r[NS];
  assign out_side  = side_r[NS];
endmodule

/* src/tlik_cordic.sv */
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30, one iteration per stage.
// Depends on tlik_pkg for the arctangent table and accumulator width.
module tlik_cordic #(
  parameter int unsigned XY_W   = 48,
  parameter int unsigned STAGES = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [XY_W-1:0]        in_y,
  input  logic signed [XY_W-1:0]        in_x,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic signed [tlik_pkg::ACC_W-1:0] out_angle,
  output logic [SIDE_W-1:0]             out_side
);
  import tlik_pkg::*;

  localparam int unsigned W = XY_W + 3;   // growth headroom
  localparam int unsigned NS = (STAGES < 32) ? STAGES : 32;

  logic                    vld [NS+2];
  logic signed [W-1:0]     xs  [NS+2];
  logic signed [W-1:0]     ys  [NS+2];
  logic signed [ACC_W-1:0] ang [NS+2];
  logic                    zer [NS+2];
  logic [SIDE_W-1:0]       sd  [NS+2];

  // Quadrant pre-rotation stage.
  logic signed [W-1:0] x0, y0;
  logic signed [ACC_W-1:0] a0;
  always_comb begin
    x0 = W'(in_x);
    y0 = W'(in_y);
    a0 = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0 = W'(in_y);
        y0 = -W'(in_x);
        a0 = Q30_HALF_PI;
      end else begin
        x0 = -W'(in_y);
        y0 = W'(in_x);
        a0 = -Q30_HALF_PI;
      end
    end
  end

  logic                    pv_r;
  logic signed [W-1:0]     px_r, py_r;
  logic signed [ACC_W-1:0] pa_r;
  logic                    pz_r;
  logic [SIDE_W-1:0]       ps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= in_valid;
    end
    if (adv) begin
      px_r <= x0;
      py_r <= y0;
      pa_r <= a0;
      pz_r <= (in_x == '0) && (in_y == '0);
      ps_r <= in_side;
    end
  end
  always_comb begin
    vld[0] = pv_r; xs[0] = px_r; ys[0] = py_r;
    ang[0] = pa_r; zer[0] = pz_r; sd[0] = ps_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_it
    logic signed [ACC_W-1:0] step;
    logic signed [W-1:0] nx, ny;
    logic signed [ACC_W-1:0] na;
    always_comb begin
      step = ACC_W'(signed'({1'b0, atan_q30(5'(i))}));
      if (ys[i] > 0) begin
        nx = xs[i] + (ys[i] >>> i);
        ny = ys[i] - (xs[i] >>> i);
        na = ang[i] + step;
      end else begin
        nx = xs[i] - (ys[i] >>> i);
        ny = ys[i] + (xs[i] >>> i);
        na = ang[i] - step;
      end
    end
    logic                    v_r;
    logic signed [W-1:0]     x_r, y_r;
    logic signed [ACC_W-1:0] a_r;
    logic                    z_r;
    logic [SIDE_W-1:0]       s_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vld[i];
      end
      if (adv) begin
        x_r <= nx; y_r <= ny; a_r <= na; z_r <= zer[i]; s_r <= sd[i];
      end
    end
    always_comb begin
      vld[i+1] = v_r; xs[i+1] = x_r; ys[i+1] = y_r;
      ang[i+1] = a_r; zer[i+1] = z_r; sd[i+1] = s_r;
    end
  end

  assign vld[NS+1] = vld[NS];
  assign xs[NS+1]  = xs[NS];
  assign ys[NS+1]  = ys[NS];
  assign ang[NS+1] = ang[NS];
  assign zer[NS+1] = zer[NS];
  assign sd[NS+1]  = sd[NS];

  assign out_valid = vld[NS+1];
  assign out_angle = zer[NS+1] ? '0 : ang[NS+1];
  assign out_side  = sd[NS+1];
endmodule

/* test/tb_two_link_arm_inverse_kinematics_unit.sv */
// Self-checking bench for two_link_arm_inverse_kinematics_unit: directed and random
// targets under several register settings, with random input gaps and random output stalls.
// Depends on tlik_pkg and the unit itself.
module tb_two_link_arm_inverse_kinematics_unit;
  import tlik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 18;
  localparam logic [2:0] REG_UNUSED = 3'd7;  // decodes to nothing
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [16:0] a;
    logic signed [16:0] b;
    status_t st;
  } ik_word_t;

  class ik_scoreboard;
    ik_word_t pending[$];
    int fails;
    longint unsigned link;
    longint a_lo, a_hi, b_lo, b_hi, pinch, extend;
    longint atan_tab[16];

    function new();
      atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                   64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                   64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                   64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
      fails = 0;
      link = 4096; a_lo = 5719; a_hi = 20018; b_lo = 2145; b_hi = 18588;
      pinch = 9294; extend = 9294;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_LINK:   link = v;
        REG_A_MIN:  a_lo = v;
        REG_A_MAX:  a_hi = v;
        REG_B_MIN:  b_lo = v;
        REG_B_MAX:  b_hi = v;
        REG_PINCH:  pinch = v;
        REG_EXTEND: extend = v;
        default: ;
      endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    // vectoring CORDIC, Q30 radians; quadrant fix-up when x is negative
    function longint vec_angle(longint y, longint x);
      longint ang, t, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; ang = HALF_PI_Q30;
        end else begin
          t = x; x = -y; y = t; ang = -HALF_PI_Q30;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; ang = ang + atan_tab[i];
        end else begin
          x = x - ys; y = y + xs; ang = ang - atan_tab[i];
        end
      end
      return ang;
    endfunction

    function longint round_angle(longint q30);
      longint v;
      v = (q30 + (64'sd1 <<< 16)) >>> 17;
      if (v < -65536) v = -65536;
      if (v > 65535) v = 65535;
      return v;
    endfunction

    function void note_target(logic signed [CW-1:0] tx, logic signed [CW-1:0] tz);
      longint x, z, th, off, a, b;
      longint unsigned s, lim;
      ik_word_t w;
      x = tx;
      z = tz;
      s = longint'(x * x) + longint'(z * z);
      lim = 4 * link * link;
      if (s > lim) begin
        w.a = '0; w.b = '0; w.st = ST_UNREACH;
      end else begin
        th = vec_angle(x * 64'sd16777216, z * 64'sd16777216);
        off = vec_angle(longint'(floor_sqrt((lim - s) << 16)),
                        longint'(floor_sqrt(s << 16)));
        a = round_angle(PI_Q30 - th - off);
        b = round_angle(HALF_PI_Q30 - th + off);
        if (!(a > a_lo && a < a_hi)) w.st = ST_A_RANGE;
        else if (!(b > b_lo && b < b_hi)) w.st = ST_B_RANGE;
        else if (!(a + pinch > b)) w.st = ST_PINCH;
        else if (!(a - b > extend)) w.st = ST_EXTEND;
        else w.st = ST_OK;
        w.a = a[16:0];
        w.b = b[16:0];
      end
      pending.push_back(w);
    endfunction

    function void check_word(logic signed [16:0] a, logic signed [16:0] b, logic [2:0] st);
      ik_word_t w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: a=%0d b=%0d status=%0d", a, b, st);
        fails++;
        return;
      end
      w = pending.pop_front();
      if (a !== w.a) begin
        $error("angle_a: expected %0d, got %0d", w.a, a);
        fails++;
      end
      if (b !== w.b) begin
        $error("angle_b: expected %0d, got %0d", w.b, b);
        fails++;
      end
      if (st !== w.st) begin
        $error("status: expected %0d, got %0d", w.st, st);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_target_x, in_target_z;
  logic out_valid;
  logic out_stall;
  logic signed [16:0] out_angle_a, out_angle_b;
  logic [2:0] out_status;

  ik_scoreboard sb;
  bit long_hold_req;

  two_link_arm_inverse_kinematics_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_target_x), .in_target_z(in_target_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle_a(out_angle_a), .out_angle_b(out_angle_b), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_target(logic signed [CW-1:0] x, logic signed [CW-1:0] z, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= x;
    in_target_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_target(x, z);
  endtask

  // idle the input, let every word come back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] l, logic [15:0] amin, logic [15:0] amax,
                            logic [15:0] bmin, logic [15:0] bmax, logic [15:0] pm,
                            logic [15:0] em);
    logic [15:0] vals[7];
    vals = '{l, amin, amax, bmin, bmax, pm, em};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_targets(int n);
    longint r;
    logic signed [CW-1:0] x, z;
    for (int k = 0; k < n; k++) begin
      r = 2 * longint'(sb.link);
      if (r > 131071) r = 131071;
      if ($urandom_range(0, 4) == 0) begin
        x = CW'($urandom);
        z = CW'($urandom);
      end else begin
        x = CW'(longint'($urandom_range(0, 2 * r)) - r);
        z = CW'(longint'($urandom_range(0, 2 * r)) - r);
      end
      send_target(x, z, pick_gap());
    end
  endtask

  // output side: accepted words go straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_angle_a, out_angle_b, out_status);
  end

  initial begin
    int r;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          repeat (100) @(posedge clk);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int r;
    sb = new();
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LINK;
    cfg_data = '0;
    in_valid = 1'b0;
    in_target_x = '0;
    in_target_z = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: reach boundary, quadrants, coordinate extremes
    send_target(0, 0, 0);
    send_target(8192, 0, 0);
    send_target(-8192, 0, 1);
    send_target(0, 8192, 0);
    send_target(0, -8192, 0);
    send_target(8193, 0, 2);
    send_target(131071, 131071, 0);
    send_target(-131072, -131072, 0);
    send_target(-131072, 0, 0);
    send_target(0, 131071, 0);
    send_target(1, -1, 0);
    send_target(-1, -1, 0);
    send_target(100, -5000, 0);
    send_target(-3000, -2000, 0);
    send_target(4000, 4000, 0);
    send_target(2896, 2896, 0);
    send_target(-5000, 3000, 0);
    drain();

    // zero link: only the origin reaches; wide windows, zero margins
    write_regs(16'd0, 16'd0, 16'd51472, 16'd0, 16'd51472, 16'd0, 16'd0);
    send_target(0, 0, 0);
    send_target(1, 0, 0);
    send_target(0, -1, 0);
    drain();

    // longest link, maximal pinch margin
    write_regs(16'd65535, 16'd0, 16'd51472, 16'd0, 16'd51472, 16'd51472, 16'd0);
    send_target(131070, 0, 0);
    send_target(0, -131070, 0);
    send_target(-131072, 0, 0);
    send_target(-65535, 65535, 0);
    send_target(20, 30, 0);
    drain();
    // index with no register behind it must change nothing
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);

    // back to defaults, with the long receiver hold-off to fill the pipe
    write_regs(16'd4096, 16'd5719, 16'd20018, 16'd2145, 16'd18588, 16'd9294, 16'd9294);
    long_hold_req = 1'b1;
    random_targets(500);
    drain();

    for (int p = 0; p < 5; p++) begin
      r = $urandom_range(0, 2);
      if (r == 0)
        write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 51472)),
                   16'($urandom_range(0, 51472)), 16'($urandom_range(0, 51472)),
                   16'($urandom_range(0, 51472)), 16'($urandom_range(0, 51472)),
                   16'($urandom_range(0, 51472)));
      else
        write_regs(16'($urandom_range(1, 9000)), 16'($urandom_range(0, 6000)),
                   16'($urandom_range(18000, 51472)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(16000, 51472)), 16'($urandom_range(0, 20000)),
                   16'($urandom_range(0, 4000)));
      random_targets(300);
      drain();
    end

    if (sb.fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/tlik_pkg.sv
src/tlik_isqrt.sv
src/tlik_cordic.sv
src/two_link_arm_inverse_kinematics_unit.sv
test/tb_two_link_arm_inverse_kinematics_unit.sv
